FILE: rtl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and codes of the credit flow switch port scheduler
// Holds the input and result beat formats, command codes, and the command
// bundle that the controller hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

    localparam logic [1:0] CMD_ARRIVE = 2'd0;
    localparam logic [1:0] CMD_CREDIT = 2'd1;
    localparam logic [1:0] CMD_PERIOD = 2'd2;
    localparam logic [1:0] CMD_SEND   = 2'd3;

    localparam logic KIND_CREDIT = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    localparam logic [3:0] EXIT_SIZE_RESET = 4'd8;
    localparam logic [3:0] CREDIT_MAX      = 4'd15;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  port;
        logic [31:0] payload_id;
        logic [9:0]  source_node;
        logic [9:0]  dest_node;
        logic [3:0]  out_port;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  emit_port;
        logic [31:0] out_payload;
        logic [9:0]  out_source;
        logic [9:0]  out_dest;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [31:0] payload;
        logic [9:0]  src;
        logic [9:0]  dst;
        logic [3:0]  route;
    } entry_t;

    typedef struct packed {
        logic [31:0] payload;
        logic [9:0]  src;
        logic [9:0]  dst;
    } exit_t;

    typedef struct packed {
        logic       arrive;
        logic       credit;
        logic       tick_start;
        logic       rd_entry;
        logic       cmp;
        logic       move;
        logic       rd_exit;
        logic       send;
        logic       flush;
        logic [3:0] in_idx;
        logic [3:0] out_idx;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/cfs_ctrl.sv
// ----------------------------------------------------------------------------
// cfs_ctrl: scheduler sequencer
// Walks output ports and entry FIFO heads for period ticks, and output ports
// for send ticks, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_ctrl #(
    parameter int PORTS = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           command,
    output logic                      busy,
    output cfs_pkg::ctrl_cmd_t        cmd
);

    localparam int PW = $clog2(PORTS);
    localparam logic [PW-1:0] LAST_IDX = PW'(PORTS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_P_RD  = 3'd1;
    localparam logic [2:0] ST_P_CMP = 3'd2;
    localparam logic [2:0] ST_P_MOV = 3'd3;
    localparam logic [2:0] ST_S_RD  = 3'd4;
    localparam logic [2:0] ST_S_EM  = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] in_idx_reg, in_idx_next;
    logic [PW-1:0] out_idx_reg, out_idx_next;
    logic          acc;

    assign busy = (state_reg != ST_IDLE);
    assign acc  = start && !busy;

    always_comb
    begin
        state_next   = state_reg;
        in_idx_next  = in_idx_reg;
        out_idx_next = out_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && command == cfs_pkg::CMD_PERIOD)
                begin
                    state_next   = ST_P_RD;
                    in_idx_next  = '0;
                    out_idx_next = '0;
                end
                else if (acc && command == cfs_pkg::CMD_SEND)
                begin
                    state_next   = ST_S_RD;
                    out_idx_next = '0;
                end
            end
            ST_P_RD:
                state_next = ST_P_CMP;
            ST_P_CMP:
            begin
                if (in_idx_reg == LAST_IDX)
                    state_next = ST_P_MOV;
                else
                begin
                    in_idx_next = in_idx_reg + 1'b1;
                    state_next  = ST_P_RD;
                end
            end
            ST_P_MOV:
            begin
                in_idx_next = '0;
                if (out_idx_reg == LAST_IDX)
                    state_next = ST_FLUSH;
                else
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    state_next   = ST_P_RD;
                end
            end
            ST_S_RD:
                state_next = ST_S_EM;
            ST_S_EM:
            begin
                if (out_idx_reg == LAST_IDX)
                    state_next = ST_FLUSH;
                else
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    state_next   = ST_S_RD;
                end
            end
            ST_FLUSH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_idx_reg  <= '0;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            in_idx_reg  <= in_idx_next;
            out_idx_reg <= out_idx_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.arrive     = acc && command == cfs_pkg::CMD_ARRIVE;
        cmd.credit     = acc && command == cfs_pkg::CMD_CREDIT;
        cmd.tick_start = acc && command == cfs_pkg::CMD_PERIOD;
        cmd.rd_entry   = (state_reg == ST_P_RD);
        cmd.cmp        = (state_reg == ST_P_CMP);
        cmd.move       = (state_reg == ST_P_MOV);
        cmd.rd_exit    = (state_reg == ST_S_RD);
        cmd.send       = (state_reg == ST_S_EM);
        cmd.flush      = (state_reg == ST_FLUSH);
        cmd.in_idx     = 4'(in_idx_reg);
        cmd.out_idx    = 4'(out_idx_reg);
    end

endmodule

`default_nettype wire

FILE: rtl/cfs_dpath.sv
// ----------------------------------------------------------------------------
// cfs_dpath: FIFO storage, counters, arbitration and result staging
// Entry and exit FIFOs live in two memories; per-port counts, read pointers
// and credits are registers. One result is held back so that last can be set.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_dpath #(
    parameter int PORTS       = 4,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfs_pkg::ctrl_cmd_t   cmd,
    input  wire cfs_pkg::item_t       item,
    input  wire logic                 cfg_we,
    input  wire logic [3:0]           cfg_wdata,
    output logic                      result_valid,
    output cfs_pkg::result_t          result
);

    localparam int PW      = $clog2(PORTS);
    localparam int SW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = PORTS * QUEUE_DEPTH;
    localparam int MAW     = $clog2(ENTRIES);

    cfs_pkg::entry_t entry_mem [ENTRIES];
    cfs_pkg::exit_t  exit_mem  [ENTRIES];

    logic [CW-1:0] ecnt_reg [PORTS];
    logic [SW-1:0] eptr_reg [PORTS];
    logic [CW-1:0] xcnt_reg [PORTS];
    logic [SW-1:0] xptr_reg [PORTS];
    logic [3:0]    credit_reg [PORTS];
    logic [3:0]    size_reg;

    cfs_pkg::entry_t erd_reg;
    cfs_pkg::exit_t  xrd_reg;

    logic          best_found_reg;
    logic [PW-1:0] best_idx_reg;
    logic [31:0]   best_pay_reg;
    logic [9:0]    best_src_reg;
    logic [9:0]    best_dst_reg;

    logic             pend_valid_reg;
    cfs_pkg::result_t pend_reg;
    logic             out_valid_reg;
    cfs_pkg::result_t out_reg;

    logic [PW-1:0] in_i, out_o, a_idx, c_idx;
    logic          a_ok, c_ok;
    logic [CW:0]   a_sum;
    logic [SW-1:0] a_slot;
    logic [7:0]    cap;
    logic          take, can_move, can_send;
    logic          new_valid;
    cfs_pkg::result_t new_res;
    cfs_pkg::result_t flush_res;

    function automatic logic [MAW-1:0] maddr(input logic [PW-1:0] p, input logic [SW-1:0] s);
        maddr = MAW'(p) * MAW'(QUEUE_DEPTH) + MAW'(s);
    endfunction

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] s);
        wrap_inc = (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    assign in_i  = cmd.in_idx[PW-1:0];
    assign out_o = cmd.out_idx[PW-1:0];
    assign a_idx = item.port[PW-1:0];
    assign c_idx = item.port[PW-1:0];
    assign a_ok  = (5'(item.port) < 5'(PORTS)) && (5'(item.out_port) < 5'(PORTS))
                   && (ecnt_reg[a_idx] < CW'(QUEUE_DEPTH));
    assign c_ok  = (5'(item.port) < 5'(PORTS));

    // The append slot wraps at most once, so one compare and subtract will do.
    assign a_sum  = (CW+1)'(eptr_reg[a_idx]) + (CW+1)'(ecnt_reg[a_idx]);
    assign a_slot = (a_sum >= (CW+1)'(QUEUE_DEPTH)) ? SW'(a_sum - (CW+1)'(QUEUE_DEPTH))
                                                     : SW'(a_sum);

    logic [CW:0]   x_sum;
    logic [SW-1:0] x_slot;
    assign x_sum  = (CW+1)'(xptr_reg[out_o]) + (CW+1)'(xcnt_reg[out_o]);
    assign x_slot = (x_sum >= (CW+1)'(QUEUE_DEPTH)) ? SW'(x_sum - (CW+1)'(QUEUE_DEPTH))
                                                     : SW'(x_sum);

    assign cap = (8'(size_reg) < 8'(QUEUE_DEPTH)) ? 8'(size_reg) : 8'(QUEUE_DEPTH);

    assign take = cmd.cmp && (ecnt_reg[in_i] != '0) && (erd_reg.route == 4'(out_o))
                  && (!best_found_reg || erd_reg.payload < best_pay_reg);
    assign can_move = cmd.move && best_found_reg && (8'(xcnt_reg[out_o]) < cap);
    assign can_send = cmd.send && (credit_reg[out_o] != 4'd0) && (xcnt_reg[out_o] != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.arrive && a_ok)
            entry_mem[maddr(a_idx, a_slot)] <= '{payload: item.payload_id,
                                                 src: item.source_node,
                                                 dst: item.dest_node,
                                                 route: item.out_port};
        if (cmd.rd_entry)
            erd_reg <= entry_mem[maddr(in_i, eptr_reg[in_i])];
    end

    always_ff @(posedge clk)
    begin
        if (can_move)
            exit_mem[maddr(out_o, x_slot)] <= '{payload: best_pay_reg,
                                                src: best_src_reg,
                                                dst: best_dst_reg};
        if (cmd.rd_exit)
            xrd_reg <= exit_mem[maddr(out_o, xptr_reg[out_o])];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= in_i;
            best_pay_reg <= erd_reg.payload;
            best_src_reg <= erd_reg.src;
            best_dst_reg <= erd_reg.dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= cfs_pkg::EXIT_SIZE_RESET;
            best_found_reg <= 1'b0;
            for (int k = 0; k < PORTS; k++)
            begin
                ecnt_reg[k]   <= '0;
                eptr_reg[k]   <= '0;
                xcnt_reg[k]   <= '0;
                xptr_reg[k]   <= '0;
                credit_reg[k] <= cfs_pkg::EXIT_SIZE_RESET;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
                for (int k = 0; k < PORTS; k++)
                    credit_reg[k] <= cfg_wdata;
            end
            else if (cmd.credit && c_ok && credit_reg[c_idx] != cfs_pkg::CREDIT_MAX)
                credit_reg[c_idx] <= credit_reg[c_idx] + 4'd1;
            else if (can_send)
                credit_reg[out_o] <= credit_reg[out_o] - 4'd1;

            if (cmd.arrive && a_ok)
                ecnt_reg[a_idx] <= ecnt_reg[a_idx] + 1'b1;

            if (cmd.tick_start || cmd.move)
                best_found_reg <= 1'b0;
            else if (take)
                best_found_reg <= 1'b1;

            if (can_move)
            begin
                ecnt_reg[best_idx_reg] <= ecnt_reg[best_idx_reg] - 1'b1;
                eptr_reg[best_idx_reg] <= wrap_inc(eptr_reg[best_idx_reg]);
                xcnt_reg[out_o]        <= xcnt_reg[out_o] + 1'b1;
            end

            if (can_send)
            begin
                xcnt_reg[out_o] <= xcnt_reg[out_o] - 1'b1;
                xptr_reg[out_o] <= wrap_inc(xptr_reg[out_o]);
            end
        end
    end

    always_comb
    begin
        new_valid = can_move || can_send;
        new_res   = '0;
        if (can_move)
        begin
            new_res.kind      = cfs_pkg::KIND_CREDIT;
            new_res.emit_port = 4'(best_idx_reg);
        end
        else
        begin
            new_res.kind        = cfs_pkg::KIND_PACKET;
            new_res.emit_port   = 4'(out_o);
            new_res.out_payload = xrd_reg.payload;
            new_res.out_source  = xrd_reg.src;
            new_res.out_dest    = xrd_reg.dst;
        end
    end

    always_comb
    begin
        flush_res      = pend_reg;
        flush_res.last = 1'b1;
    end

    // A result is held back until the next result or the flush, so that the tick's final beat can carry last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            if (new_valid)
            begin
                if (pend_valid_reg)
                    out_valid_reg <= 1'b1;
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush && pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (new_valid)
        begin
            pend_reg <= new_res;
            out_reg  <= pend_reg;
        end
        else if (cmd.flush)
            out_reg <= flush_res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

FILE: rtl/credit_flow_switch_port_scheduler_core.sv
// ----------------------------------------------------------------------------
// credit_flow_switch_port_scheduler_core: input-queued switch scheduler
// Entry FIFOs per input, exit FIFOs and credits per output, with a sequencer
// that arbitrates on period ticks and sends on send ticks.
// ----------------------------------------------------------------------------
// An arrival or credit beat is applied when it is accepted and never raises
// busy. A period tick walks, for every output port, each input's entry FIFO
// head through the single read port of the entry memory, a read and then a
// compare per head, and then moves the winner. A send tick reads the exit
// memory once per output port. Results leave with result_valid and cannot be
// held off; the last beat of a tick comes out in the first cycle that busy is
// low. Arrival and credit beats never produce results.
`default_nettype none

module credit_flow_switch_port_scheduler_core #(
    parameter int PORTS       = 4,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire cfs_pkg::item_t       item,
    input  wire logic                 cfg_we,
    input  wire logic [3:0]           cfg_wdata,
    output logic                      result_valid,
    output cfs_pkg::result_t          result
);

    cfs_pkg::ctrl_cmd_t cmd;

    cfs_ctrl #(
        .PORTS (PORTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .busy    (busy),
        .cmd     (cmd)
    );

    cfs_dpath #(
        .PORTS       (PORTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    a_no_result_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && $past(!busy)) |-> !result_valid)
        else $error("result beat while the scheduler was idle");

    a_last_ends_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result beat after the last beat of a tick");

    a_emit_port_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (5'(result.emit_port) < 5'(PORTS)))
        else $error("result on a port that does not exist");

    a_tick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.command == cfs_pkg::CMD_PERIOD
                            || item.command == cfs_pkg::CMD_SEND)) |=> busy)
        else $error("tick accepted without entering the scan");

endmodule

`default_nettype wire

FILE: dv/tb_credit_flow_switch_port_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_credit_flow_switch_port_scheduler_core: self-checking switch scheduler bench
// Drives arrival, credit, period and send beats through a directed table and
// a random phase under several exit buffer sizes, predicts every credit and
// packet result in a local model of the FIFOs and credits, and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_credit_flow_switch_port_scheduler_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPORT = 4;
    localparam int QDEPTH = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cfs_pkg::item_t item;
    logic cfg_we;
    logic [3:0] cfg_wdata;
    logic result_valid;
    cfs_pkg::result_t result;

    credit_flow_switch_port_scheduler_core #(
        .PORTS(NPORT),
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Predictor state.
    cfs_pkg::entry_t  entry_q [NPORT][$];
    cfs_pkg::exit_t   exit_q [NPORT][$];
    logic [3:0]       credit_cnt [NPORT];
    logic [3:0]       exit_size;
    cfs_pkg::result_t pending_results [$];

    int errors;
    int cycles;
    int items_sent;
    int results_seen;
    int packets_seen;

    function automatic cfs_pkg::result_t make_result(logic kind, logic [3:0] prt,
                                                     cfs_pkg::exit_t pkt);
        cfs_pkg::result_t r;
        r.kind = kind;
        r.emit_port = prt;
        r.out_payload = pkt.payload;
        r.out_source = pkt.src;
        r.out_dest = pkt.dst;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic reload_size(input logic [3:0] sz);
        exit_size = sz;
        for (int i = 0; i < NPORT; i++)
        begin
            credit_cnt[i] = sz;
        end
    endtask

    // Applies one beat to the switch model and queues the results it causes.
    task automatic schedule_beat(input cfs_pkg::item_t it);
        cfs_pkg::result_t produced [$];
        int cap;
        int best;
        cfs_pkg::exit_t pkt;
        cap = (exit_size < QDEPTH) ? exit_size : QDEPTH;
        case (it.command)
            cfs_pkg::CMD_ARRIVE:
            begin
                if (it.port < NPORT && it.out_port < NPORT
                    && entry_q[it.port].size() < QDEPTH)
                begin
                    entry_q[it.port].push_back({it.payload_id, it.source_node,
                                                it.dest_node, it.out_port});
                end
            end
            cfs_pkg::CMD_CREDIT:
            begin
                if (it.port < NPORT && credit_cnt[it.port] < cfs_pkg::CREDIT_MAX)
                begin
                    credit_cnt[it.port]++;
                end
            end
            cfs_pkg::CMD_PERIOD:
            begin
                for (int o = 0; o < NPORT; o++)
                begin
                    best = -1;
                    for (int i = 0; i < NPORT; i++)
                    begin
                        if (entry_q[i].size() != 0 && entry_q[i][0].route == o
                            && (best < 0 || entry_q[i][0].payload < entry_q[best][0].payload))
                        begin
                            best = i;
                        end
                    end
                    if (best >= 0 && exit_q[o].size() < cap)
                    begin
                        pkt = {entry_q[best][0].payload, entry_q[best][0].src,
                               entry_q[best][0].dst};
                        exit_q[o].push_back(pkt);
                        void'(entry_q[best].pop_front());
                        produced.push_back(make_result(cfs_pkg::KIND_CREDIT, best[3:0], '0));
                    end
                end
            end
            default:
            begin
                for (int o = 0; o < NPORT; o++)
                begin
                    if (credit_cnt[o] > 0 && exit_q[o].size() > 0)
                    begin
                        credit_cnt[o]--;
                        pkt = exit_q[o].pop_front();
                        produced.push_back(make_result(cfs_pkg::KIND_PACKET, o[3:0], pkt));
                    end
                end
            end
        endcase
        if (produced.size() > 0)
        begin
            produced[produced.size() - 1].last = 1'b1;
        end
        foreach (produced[k])
        begin
            pending_results.push_back(produced[k]);
        end
    endtask

    // Result checker: the bench cannot stall results, so every strobe counts.
    always @(posedge clk)
    begin
        cfs_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (result.kind == cfs_pkg::KIND_PACKET)
            begin
                packets_seen++;
            end
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual %p", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.kind != want.kind || result.emit_port != want.emit_port
                    || result.out_payload != want.out_payload
                    || result.out_source != want.out_source
                    || result.out_dest != want.out_dest || result.last != want.last)
                begin
                    errors++;
                    $display("%0t result mismatch: expected %p, actual %p",
                             $time, want, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    int burst_left;

    // Sends one beat; the sender idles for a random gap, possibly none, between bursts of random length.
    task automatic drive_beat(input cfs_pkg::item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        schedule_beat(it);
        items_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * NPORT * NPORT + NPORT + 8) @(posedge clk);
    endtask

    task automatic write_size(input logic [3:0] sz);
        cfg_we <= 1'b1;
        cfg_wdata <= sz;
        @(posedge clk);
        cfg_we <= 1'b0;
        reload_size(sz);
    endtask

    function automatic cfs_pkg::item_t beat(logic [1:0] cmd, int unsigned prt,
                                            int unsigned pay, int unsigned src,
                                            int unsigned dst, int unsigned route);
        cfs_pkg::item_t it;
        it.command = cmd;
        it.port = 4'(prt);
        it.payload_id = pay;
        it.source_node = 10'(src);
        it.dest_node = 10'(dst);
        it.out_port = 4'(route);
        return it;
    endfunction

    function automatic cfs_pkg::item_t random_beat();
        cfs_pkg::item_t it;
        int pick;
        it = cfs_pkg::item_t'(62'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        // Half the beats are arrivals, mostly in range, so the FIFOs fill and arbitration has work.
        if (pick < 50)
        begin
            it.command = cfs_pkg::CMD_ARRIVE;
            if ($urandom_range(0, 9) != 0)
            begin
                it.port = 4'($urandom_range(0, NPORT - 1));
                it.out_port = 4'($urandom_range(0, NPORT - 1));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                it.payload_id = $urandom_range(0, 7);
            end
        end
        else if (pick < 60)
        begin
            it.command = cfs_pkg::CMD_CREDIT;
        end
        else if (pick < 80)
        begin
            it.command = cfs_pkg::CMD_PERIOD;
        end
        else
        begin
            it.command = cfs_pkg::CMD_SEND;
        end
        return it;
    endfunction

    typedef struct {
        cfs_pkg::item_t   stim;
        logic             check_fixed;
        cfs_pkg::result_t fixed_result;
    } table_row_t;

    table_row_t directed [$];

    initial
    begin
        logic [3:0] sizes [5];
        table_row_t row;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        results_seen = 0;
        packets_seen = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        reload_size(cfs_pkg::EXIT_SIZE_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Fixed results are the ones obvious from the rules.
        row.check_fixed = 1'b0;
        row.fixed_result = '0;
        row.stim = beat(cfs_pkg::CMD_PERIOD, 0, 0, 0, 0, 0);      directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_SEND, 0, 0, 0, 0, 0);        directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_ARRIVE, 0, 'hFFFF_FFFF, 'h3FF, 'h3FF, 3);
        directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_ARRIVE, 1, 'hFFFF_FFFF, 0, 0, 3);
        directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_ARRIVE, 2, 0, 'h2AA, 'h155, 0);
        directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_ARRIVE, 3, 5, 1, 2, 1);      directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_ARRIVE, 4, 1, 1, 1, 0);      directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_ARRIVE, 15, 1, 1, 1, 0);     directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_ARRIVE, 0, 1, 1, 1, 15);     directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_CREDIT, 9, 0, 0, 0, 0);      directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_CREDIT, 0, 0, 0, 0, 0);      directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_PERIOD, 0, 0, 0, 0, 0);      directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_PERIOD, 0, 0, 0, 0, 0);      directed.push_back(row);
        row.stim = beat(cfs_pkg::CMD_SEND, 0, 0, 0, 0, 0);        directed.push_back(row);
        for (int k = 0; k < 9; k++)
        begin
            row.stim = beat(cfs_pkg::CMD_ARRIVE, 2, 32'd100 - k, k, k, 2);
            directed.push_back(row);
        end
        row.stim = beat(cfs_pkg::CMD_PERIOD, 0, 0, 0, 0, 0);
        row.check_fixed = 1'b1;
        row.fixed_result = '{kind: cfs_pkg::KIND_CREDIT, emit_port: 4'd2, out_payload: 32'd0,
                             out_source: 10'd0, out_dest: 10'd0, last: 1'b1};
        directed.push_back(row);

        foreach (directed[r])
        begin
            drive_beat(directed[r].stim);
            if (directed[r].check_fixed && (pending_results.size() != 1
                || pending_results[0] !== directed[r].fixed_result))
            begin
                errors++;
                $display("%0t directed row %0d: expected %p, actual %p",
                         $time, r, directed[r].fixed_result, pending_results);
            end
        end
        wait_idle();

        // Random phases over several exit buffer sizes, extremes included.
        sizes = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8};
        foreach (sizes[s])
        begin
            write_size(sizes[s]);
            for (int n = 0; n < 47; n++)
            begin
                drive_beat(random_beat());
            end
            wait_idle();
        end

        $display("Covered %0d beats over five exit buffer sizes.", items_sent);
        $display("Checked %0d results, %0d of them packets sent downstream.",
                 results_seen, packets_seen);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
